### hw/rtl/dfr_pkg.sv
// Shared types and constants for the delimited frame receiver.
// No dependencies; used by every module of the block.
package dfr_pkg;

    localparam int DEF_BUFFER_DEPTH = 512;
    localparam int DEF_MAX_READ     = 64;

    localparam int BYTE_W   = 8;
    localparam int OP_W     = 2;
    localparam int CNT_W    = 7;
    localparam int STATUS_W = 4;
    localparam int LEFT_W   = 10;
    localparam int MSG_W    = 16;
    localparam int RUN_W    = 4;
    localparam int CADDR_W  = 2;

    localparam logic [OP_W-1:0] OP_RECEIVE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ    = 2'd1;
    localparam logic [OP_W-1:0] OP_DISCARD = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

    localparam logic [STATUS_W-1:0] STS_STORED        = 4'd0;
    localparam logic [STATUS_W-1:0] STS_FRAME_DONE    = 4'd1;
    localparam logic [STATUS_W-1:0] STS_BUSY          = 4'd2;
    localparam logic [STATUS_W-1:0] STS_OVERFLOW      = 4'd3;
    localparam logic [STATUS_W-1:0] STS_START_MISSING = 4'd4;
    localparam logic [STATUS_W-1:0] STS_DATA          = 4'd5;
    localparam logic [STATUS_W-1:0] STS_NO_MESSAGE    = 4'd6;
    localparam logic [STATUS_W-1:0] STS_DISCARDED     = 4'd7;
    localparam logic [STATUS_W-1:0] STS_CLEARED       = 4'd8;
    localparam logic [STATUS_W-1:0] STS_NOTHING_READ  = 4'd9;

    localparam logic [CADDR_W-1:0] REG_START_BYTE = 2'd0;
    localparam logic [CADDR_W-1:0] REG_END_BYTE   = 2'd1;
    localparam logic [CADDR_W-1:0] REG_DELIM_CNT  = 2'd2;

    localparam logic [BYTE_W-1:0] RST_START_BYTE = 8'd254;
    localparam logic [BYTE_W-1:0] RST_END_BYTE   = 8'd253;
    localparam logic [RUN_W-1:0]  RST_DELIM_CNT  = 4'd5;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] end_byte;
        logic [RUN_W-1:0]  delimiter_count;
    } dfr_cfg_t;

endpackage

### hw/rtl/dfr_byte_ram.sv
// Byte buffer: one write port, one read port, registered read data.
// Depends on dfr_pkg for the byte width and the default depth.
module dfr_byte_ram #(
    parameter int DEPTH = dfr_pkg::DEF_BUFFER_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [dfr_pkg::BYTE_W-1:0] wdata,
    input  logic                       re,
    input  logic [AW-1:0]              raddr,
    output logic [dfr_pkg::BYTE_W-1:0] rdata
);

    logic [dfr_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [dfr_pkg::BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/dfr_ctrl.sv
// Frame control: run tracking, buffer indexes, read sequencer, output register.
// Depends on dfr_pkg; drives the ports of dfr_byte_ram.
module dfr_ctrl #(
    parameter int BUFFER_DEPTH = dfr_pkg::DEF_BUFFER_DEPTH,
    parameter int MAX_READ     = dfr_pkg::DEF_MAX_READ,
    parameter int AW           = $clog2(BUFFER_DEPTH)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dfr_pkg::dfr_cfg_t            cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [dfr_pkg::OP_W-1:0]     operation,
    input  logic [dfr_pkg::BYTE_W-1:0]   rx_byte,
    input  logic [dfr_pkg::CNT_W-1:0]    byte_count,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [dfr_pkg::STATUS_W-1:0] status,
    output logic [dfr_pkg::BYTE_W-1:0]   data_byte,
    output logic                         last,
    output logic [dfr_pkg::LEFT_W-1:0]   bytes_left,
    output logic [dfr_pkg::MSG_W-1:0]    message_number,
    output logic                         ram_we,
    output logic [AW-1:0]                ram_waddr,
    output logic [dfr_pkg::BYTE_W-1:0]   ram_wdata,
    output logic                         ram_re,
    output logic [AW-1:0]                ram_raddr,
    input  logic [dfr_pkg::BYTE_W-1:0]   ram_rdata
);

    localparam int IW = $clog2(BUFFER_DEPTH + 1);
    localparam int RW = $clog2(MAX_READ + 1);
    localparam int NW = (IW > dfr_pkg::CNT_W) ? IW : dfr_pkg::CNT_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic                          state_reg, state_next;
    logic [IW-1:0]                 write_index_reg, write_index_next;
    logic [IW-1:0]                 read_index_reg, read_index_next;
    logic [IW-1:0]                 start_index_reg, start_index_next;
    logic                          frame_ready_reg, frame_ready_next;
    logic                          start_seen_reg, start_seen_next;
    logic                          error_latched_reg, error_latched_next;
    logic [dfr_pkg::RUN_W-1:0]     start_run_reg, start_run_next;
    logic [dfr_pkg::RUN_W-1:0]     end_run_reg, end_run_next;
    logic [dfr_pkg::MSG_W-1:0]     frames_done_reg, frames_done_next;
    logic [RW-1:0]                 rd_cnt_reg, rd_cnt_next;

    logic                          out_valid_reg, out_valid_next;
    logic [dfr_pkg::STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [dfr_pkg::BYTE_W-1:0]    out_data_reg, out_data_next;
    logic                          out_last_reg, out_last_next;
    logic [dfr_pkg::LEFT_W-1:0]    out_left_reg, out_left_next;
    logic [dfr_pkg::MSG_W-1:0]     out_msg_reg, out_msg_next;

    logic                          slot_free;
    logic                          accept;
    logic                          out_load;
    logic                          do_empty;
    logic                          seen;
    logic [IW-1:0]                 sidx;
    logic [dfr_pkg::RUN_W-1:0]     srun;
    logic [dfr_pkg::RUN_W-1:0]     erun;
    logic [IW-1:0]                 left;
    logic [NW-1:0]                 n_ext;
    logic [RW-1:0]                 n_rd;
    logic [IW-1:0]                 ri;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;

    assign left = write_index_reg - read_index_reg;

    always_comb
    begin
        state_next         = state_reg;
        write_index_next   = write_index_reg;
        read_index_next    = read_index_reg;
        start_index_next   = start_index_reg;
        frame_ready_next   = frame_ready_reg;
        start_seen_next    = start_seen_reg;
        error_latched_next = error_latched_reg;
        start_run_next     = start_run_reg;
        end_run_next       = end_run_reg;
        frames_done_next   = frames_done_reg;
        rd_cnt_next        = rd_cnt_reg;

        out_load        = 1'b0;
        out_status_next = out_status_reg;
        out_data_next   = '0;
        out_last_next   = 1'b1;
        out_left_next   = '0;
        do_empty        = 1'b0;

        ram_we    = 1'b0;
        ram_waddr = write_index_reg[AW-1:0];
        ram_wdata = rx_byte;
        ram_re    = 1'b0;
        ram_raddr = read_index_reg[AW-1:0];

        seen  = start_seen_reg;
        sidx  = start_index_reg;
        srun  = '0;
        erun  = '0;
        n_ext = (NW'(byte_count) < NW'(left)) ? NW'(byte_count) : NW'(left);
        n_rd  = (n_ext > NW'(MAX_READ)) ? RW'(MAX_READ) : RW'(n_ext);
        ri    = read_index_reg + IW'(n_ext);

        if (accept)
        begin
            out_load = 1'b1;
            if (error_latched_reg)
            begin
                out_status_next = dfr_pkg::STS_START_MISSING;
            end
            else
            begin
                case (operation)
                    dfr_pkg::OP_RECEIVE:
                    begin
                        if (frame_ready_reg)
                        begin
                            out_status_next = dfr_pkg::STS_BUSY;
                            out_left_next   = dfr_pkg::LEFT_W'(left);
                        end
                        else if (write_index_reg >= IW'(BUFFER_DEPTH))
                        begin
                            out_status_next = dfr_pkg::STS_OVERFLOW;
                        end
                        else
                        begin
                            ram_we           = 1'b1;
                            write_index_next = write_index_reg + IW'(1);
                            if (!start_seen_reg && start_run_reg == cfg.delimiter_count)
                            begin
                                seen = 1'b1;
                                sidx = write_index_reg;
                            end
                            if (rx_byte == cfg.start_byte)
                            begin
                                srun = (start_run_reg == '1) ? start_run_reg
                                                             : start_run_reg + 4'd1;
                            end
                            if (rx_byte == cfg.end_byte)
                            begin
                                erun = (end_run_reg == '1) ? end_run_reg : end_run_reg + 4'd1;
                            end
                            start_seen_next  = seen;
                            start_index_next = sidx;
                            start_run_next   = srun;
                            end_run_next     = erun;
                            if (rx_byte == cfg.end_byte && erun == cfg.delimiter_count)
                            begin
                                if (!seen)
                                begin
                                    error_latched_next = 1'b1;
                                    out_status_next    = dfr_pkg::STS_START_MISSING;
                                end
                                else
                                begin
                                    frame_ready_next = 1'b1;
                                    read_index_next  = sidx;
                                    frames_done_next = frames_done_reg + 16'd1;
                                    out_status_next  = dfr_pkg::STS_FRAME_DONE;
                                    out_left_next    =
                                        dfr_pkg::LEFT_W'(write_index_next - sidx);
                                end
                            end
                            else
                            begin
                                out_status_next = dfr_pkg::STS_STORED;
                            end
                        end
                    end
                    dfr_pkg::OP_CLEAR:
                    begin
                        do_empty        = 1'b1;
                        out_status_next = dfr_pkg::STS_CLEARED;
                    end
                    dfr_pkg::OP_DISCARD:
                    begin
                        if (!frame_ready_reg)
                        begin
                            out_status_next = dfr_pkg::STS_NO_MESSAGE;
                        end
                        else
                        begin
                            out_status_next = dfr_pkg::STS_DISCARDED;
                            if (ri == write_index_reg)
                            begin
                                do_empty = 1'b1;
                            end
                            else
                            begin
                                read_index_next = ri;
                                out_left_next   = dfr_pkg::LEFT_W'(write_index_reg - ri);
                            end
                        end
                    end
                    default:
                    begin
                        if (!frame_ready_reg)
                        begin
                            out_status_next = dfr_pkg::STS_NO_MESSAGE;
                        end
                        else if (n_rd == '0)
                        begin
                            out_status_next = dfr_pkg::STS_NOTHING_READ;
                            out_left_next   = dfr_pkg::LEFT_W'(left);
                        end
                        else
                        begin
                            out_load    = 1'b0;
                            state_next  = ST_READ;
                            rd_cnt_next = n_rd;
                            ram_re      = 1'b1;
                        end
                    end
                endcase
            end
        end
        else if (state_reg == ST_READ && slot_free)
        begin
            out_load        = 1'b1;
            out_status_next = dfr_pkg::STS_DATA;
            out_data_next   = ram_rdata;
            ri              = read_index_reg + IW'(1);
            out_left_next   = dfr_pkg::LEFT_W'(write_index_reg - ri);
            read_index_next = ri;
            if (rd_cnt_reg == RW'(1))
            begin
                state_next = ST_IDLE;
                if (ri == write_index_reg)
                begin
                    do_empty = 1'b1;
                end
            end
            else
            begin
                out_last_next = 1'b0;
                rd_cnt_next   = rd_cnt_reg - RW'(1);
                ram_re        = 1'b1;
                ram_raddr     = ri[AW-1:0];
            end
        end

        if (do_empty)
        begin
            write_index_next = '0;
            read_index_next  = '0;
            frame_ready_next = 1'b0;
            end_run_next     = '0;
            start_run_next   = '0;
            start_index_next = '0;
            start_seen_next  = 1'b0;
        end

        out_msg_next   = frames_done_next;
        out_valid_next = out_load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            write_index_reg   <= '0;
            read_index_reg    <= '0;
            start_index_reg   <= '0;
            frame_ready_reg   <= 1'b0;
            start_seen_reg    <= 1'b0;
            error_latched_reg <= 1'b0;
            start_run_reg     <= '0;
            end_run_reg       <= '0;
            frames_done_reg   <= '0;
            rd_cnt_reg        <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            write_index_reg   <= write_index_next;
            read_index_reg    <= read_index_next;
            start_index_reg   <= start_index_next;
            frame_ready_reg   <= frame_ready_next;
            start_seen_reg    <= start_seen_next;
            error_latched_reg <= error_latched_next;
            start_run_reg     <= start_run_next;
            end_run_reg       <= end_run_next;
            frames_done_reg   <= frames_done_next;
            rd_cnt_reg        <= rd_cnt_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= out_status_next;
            out_data_reg   <= out_data_next;
            out_last_reg   <= out_last_next;
            out_left_reg   <= out_left_next;
            out_msg_reg    <= out_msg_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign data_byte      = out_data_reg;
    assign last           = out_last_reg;
    assign bytes_left     = out_left_reg;
    assign message_number = out_msg_reg;

    a_windex_bound: assert property (@(posedge clk) disable iff (!rst_n)
        write_index_reg <= IW'(BUFFER_DEPTH))
        else $error("write index beyond buffer");

    a_rindex_order: assert property (@(posedge clk) disable iff (!rst_n)
        frame_ready_reg |-> (read_index_reg < write_index_reg))
        else $error("pending frame with no bytes left");

    a_read_state: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (frame_ready_reg && rd_cnt_reg != '0))
        else $error("read sequencer active without pending frame");

    a_no_write_pending: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !frame_ready_reg)
        else $error("buffer written while frame pending");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        error_latched_reg |=> error_latched_reg)
        else $error("error flag dropped");

endmodule

### hw/rtl/delimited_frame_receiver.sv
// Delimited frame receiver, top level: config registers, control, byte buffer.
// Depends on dfr_pkg, dfr_ctrl and dfr_byte_ram.
// Every result but read data is loaded into the output register as its word is accepted;
// a read of n bytes moves each byte through the buffer read register, then the output
// register, one per cycle while m_tready drains it. Single-result operations take one word
// per cycle while the output register is free or being drained; a read keeps s_tready low until its last byte loads.
// Reset clears control state and loads the config defaults; buffer contents are undefined until written.
module delimited_frame_receiver #(
    parameter int BUFFER_DEPTH = dfr_pkg::DEF_BUFFER_DEPTH,
    parameter int MAX_READ     = dfr_pkg::DEF_MAX_READ
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,  // rx_byte[7:0], byte_count[14:8]
    input  logic [dfr_pkg::OP_W-1:0]       s_tuser,  // operation
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [39:0]                    m_tdata,  // data_byte, bytes_left, message_number
    output logic [dfr_pkg::STATUS_W-1:0]   m_tuser,  // status
    output logic                           m_tlast,
    input  logic                           cfg_we,
    input  logic [dfr_pkg::CADDR_W-1:0]    cfg_addr,
    input  logic [dfr_pkg::BYTE_W-1:0]     cfg_wdata
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    dfr_pkg::dfr_cfg_t          cfg_reg;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [dfr_pkg::BYTE_W-1:0] ram_wdata;
    logic                       ram_re;
    logic [AW-1:0]              ram_raddr;
    logic [dfr_pkg::BYTE_W-1:0] ram_rdata;
    logic [dfr_pkg::BYTE_W-1:0] data_byte;
    logic [dfr_pkg::LEFT_W-1:0] bytes_left;
    logic [dfr_pkg::MSG_W-1:0]  message_number;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte      <= dfr_pkg::RST_START_BYTE;
            cfg_reg.end_byte        <= dfr_pkg::RST_END_BYTE;
            cfg_reg.delimiter_count <= dfr_pkg::RST_DELIM_CNT;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                dfr_pkg::REG_START_BYTE: cfg_reg.start_byte      <= cfg_wdata;
                dfr_pkg::REG_END_BYTE:   cfg_reg.end_byte        <= cfg_wdata;
                dfr_pkg::REG_DELIM_CNT:  cfg_reg.delimiter_count <= cfg_wdata[3:0];
                default:                 cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    dfr_ctrl #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .MAX_READ     (MAX_READ),
        .AW           (AW)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .operation      (s_tuser),
        .rx_byte        (s_tdata[7:0]),
        .byte_count     (s_tdata[14:8]),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .status         (m_tuser),
        .data_byte      (data_byte),
        .last           (m_tlast),
        .bytes_left     (bytes_left),
        .message_number (message_number),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_re         (ram_re),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata)
    );

    dfr_byte_ram #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_tdata = {6'd0, message_number, bytes_left, data_byte};

endmodule
